/* design/bcd_pkg.sv */
package bcd_pkg;

    // opcodes carried by an input transaction
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register offsets
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_BANK    = 3'd1;
    localparam logic [2:0] REG_SRC_LO  = 3'd2;
    localparam logic [2:0] REG_SRC_HI  = 3'd3;
    localparam logic [2:0] REG_DST_LO  = 3'd4;
    localparam logic [2:0] REG_DST_HI  = 3'd5;
    localparam logic [2:0] REG_LEN_LO  = 3'd6;
    localparam logic [2:0] REG_LEN_HI  = 3'd7;

    // control register bits
    localparam int CTRL_START_BIT = 7;
    localparam int CTRL_DST_BIT   = 5;

    localparam int ADDR_W    = 16;
    localparam int SRC_ADDR_W = 20;
    localparam int BANK_W    = SRC_ADDR_W - (ADDR_W - 1);
    localparam int COUNT_W   = ADDR_W + 1;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  xfer_valid;
        logic                  src_is_rom;
        logic [SRC_ADDR_W-1:0] src_address;
        logic                  dst_is_cpu;
        logic [ADDR_W-1:0]     dst_address;
        logic                  last_transfer;
        logic                  busy_res;
    } t_result;

endpackage

/* design/bcd_in_if.sv */
interface bcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] reg_offset;
    logic [7:0] write_data;

    modport source(output valid, output opcode, output reg_offset, output write_data,
                   input ready);
    modport sink(input valid, input opcode, input reg_offset, input write_data,
                 output ready);
endinterface

/* design/bcd_out_if.sv */
interface bcd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        xfer_valid;
    logic        src_is_rom;
    logic [19:0] src_address;
    logic        dst_is_cpu;
    logic [15:0] dst_address;
    logic        last_transfer;
    logic        busy_res;

    modport source(output valid, output read_data, output xfer_valid, output src_is_rom,
                   output src_address, output dst_is_cpu, output dst_address,
                   output last_transfer, output busy_res, input ready);
    modport sink(input valid, input read_data, input xfer_valid, input src_is_rom,
                 input src_address, input dst_is_cpu, input dst_address,
                 input last_transfer, input busy_res, output ready);
endinterface

/* design/block_copy_dma_engine_unit.sv */
// Block copy DMA engine: register bus plus one byte transfer command per tick.
// The result of a transaction is registered in the output register, or in the skid
// stage while the output holds an untaken result. One transaction per cycle while the
// skid stage is empty; the copy counters and register file update in the cycle of acceptance.
// Reset (i_rst_n low, synchronous): all programmed and copy registers zero, engine idle, output
// and skid stages empty.
module block_copy_dma_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcd_in_if.sink     i_in,
    bcd_out_if.source  o_out
);

    // programmed registers (a copy never modifies these)
    logic [7:0]                   r_control;
    logic [7:0]                   r_bank;
    logic [bcd_pkg::ADDR_W-1:0]   r_source;
    logic [bcd_pkg::ADDR_W-1:0]   r_dest;
    logic [bcd_pkg::ADDR_W-1:0]   r_length;

    // running copy state
    logic [bcd_pkg::ADDR_W-1:0]   r_cur_source;
    logic [bcd_pkg::ADDR_W-1:0]   r_cur_dest;
    logic [bcd_pkg::COUNT_W-1:0]  r_bytes_left;
    logic                         r_active;

    logic [7:0]                   n_control;
    logic [7:0]                   n_bank;
    logic [bcd_pkg::ADDR_W-1:0]   n_source;
    logic [bcd_pkg::ADDR_W-1:0]   n_dest;
    logic [bcd_pkg::ADDR_W-1:0]   n_length;
    logic [bcd_pkg::ADDR_W-1:0]   n_cur_source;
    logic [bcd_pkg::ADDR_W-1:0]   n_cur_dest;
    logic [bcd_pkg::COUNT_W-1:0]  n_bytes_left;
    logic                         n_active;

    // output register and skid stage
    bcd_pkg::t_result             r_out;
    bcd_pkg::t_result             r_skid;
    logic                         r_out_valid;
    logic                         r_skid_valid;

    bcd_pkg::t_result             res;
    logic                         accept;
    logic                         out_take;
    logic                         out_free;

    // Input stays open as long as the skid stage is empty, so a result that
    // waits at the output does not stall the next transaction.
    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign out_take   = r_out_valid && o_out.ready;
    assign out_free   = !r_out_valid || out_take;

    // Single-pass update: result and next state from the transaction and
    // the current state.
    always_comb begin
        res          = '0;
        n_control    = r_control;
        n_bank       = r_bank;
        n_source     = r_source;
        n_dest       = r_dest;
        n_length     = r_length;
        n_cur_source = r_cur_source;
        n_cur_dest   = r_cur_dest;
        n_bytes_left = r_bytes_left;
        n_active     = r_active;

        case (i_in.opcode)
            bcd_pkg::OP_TICK: begin
                if (r_active) begin
                    res.xfer_valid = 1'b1;
                    res.src_is_rom = r_cur_source[bcd_pkg::ADDR_W-1];
                    // ROM space: bank selects the 32 KB window
                    if (r_cur_source[bcd_pkg::ADDR_W-1]) begin
                        res.src_address = {r_bank[bcd_pkg::BANK_W-1:0],
                                           r_cur_source[bcd_pkg::ADDR_W-2:0]};
                    end else begin
                        res.src_address = {{bcd_pkg::BANK_W{1'b0}},
                                           r_cur_source[bcd_pkg::ADDR_W-2:0]};
                    end
                    res.dst_is_cpu  = r_control[bcd_pkg::CTRL_DST_BIT];
                    res.dst_address = r_cur_dest;
                    n_cur_source    = r_cur_source + 1'b1;
                    n_cur_dest      = r_cur_dest + 1'b1;
                    if (r_bytes_left <= bcd_pkg::COUNT_W'(1)) begin
                        n_bytes_left      = '0;
                        n_active          = 1'b0;
                        res.last_transfer = 1'b1;
                    end else begin
                        n_bytes_left = r_bytes_left - 1'b1;
                    end
                end
            end
            bcd_pkg::OP_WRITE: begin
                // writes while a copy runs are dropped
                if (!r_active) begin
                    case (i_in.reg_offset)
                        bcd_pkg::REG_CONTROL: begin
                            n_control = i_in.write_data;
                            if (i_in.write_data[bcd_pkg::CTRL_START_BIT]) begin
                                n_cur_source = r_source;
                                n_cur_dest   = r_dest;
                                n_bytes_left = {1'b0, r_length} + 1'b1;
                                n_active     = 1'b1;
                            end
                        end
                        bcd_pkg::REG_BANK:   n_bank          = i_in.write_data;
                        bcd_pkg::REG_SRC_LO: n_source[7:0]   = i_in.write_data;
                        bcd_pkg::REG_SRC_HI: n_source[15:8]  = i_in.write_data;
                        bcd_pkg::REG_DST_LO: n_dest[7:0]     = i_in.write_data;
                        bcd_pkg::REG_DST_HI: n_dest[15:8]    = i_in.write_data;
                        bcd_pkg::REG_LEN_LO: n_length[7:0]   = i_in.write_data;
                        default:             n_length[15:8]  = i_in.write_data;
                    endcase
                end
            end
            bcd_pkg::OP_READ: begin
                // reads while busy return zero
                if (!r_active) begin
                    case (i_in.reg_offset)
                        bcd_pkg::REG_CONTROL: res.read_data = {1'b0, r_control[6:0]};
                        bcd_pkg::REG_BANK:    res.read_data = r_bank;
                        bcd_pkg::REG_SRC_LO:  res.read_data = r_source[7:0];
                        bcd_pkg::REG_SRC_HI:  res.read_data = r_source[15:8];
                        bcd_pkg::REG_DST_LO:  res.read_data = r_dest[7:0];
                        bcd_pkg::REG_DST_HI:  res.read_data = r_dest[15:8];
                        bcd_pkg::REG_LEN_LO:  res.read_data = r_length[7:0];
                        default:              res.read_data = r_length[15:8];
                    endcase
                end
            end
            default: ;  // unused opcode: no effect
        endcase

        res.busy_res = n_active;
    end

    // state update on acceptance only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= '0;
            r_bank       <= '0;
            r_source     <= '0;
            r_dest       <= '0;
            r_length     <= '0;
            r_cur_source <= '0;
            r_cur_dest   <= '0;
            r_bytes_left <= '0;
            r_active     <= 1'b0;
        end else if (accept) begin
            r_control    <= n_control;
            r_bank       <= n_bank;
            r_source     <= n_source;
            r_dest       <= n_dest;
            r_length     <= n_length;
            r_cur_source <= n_cur_source;
            r_cur_dest   <= n_cur_dest;
            r_bytes_left <= n_bytes_left;
            r_active     <= n_active;
        end
    end

    // Output register with skid: the skid stage only fills when the output
    // holds an untaken result, and drains first so order is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= accept;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (accept) begin
                    r_skid <= res;
                end
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_out.read_data;
    assign o_out.xfer_valid    = r_out.xfer_valid;
    assign o_out.src_is_rom    = r_out.src_is_rom;
    assign o_out.src_address   = r_out.src_address;
    assign o_out.dst_is_cpu    = r_out.dst_is_cpu;
    assign o_out.dst_address   = r_out.dst_address;
    assign o_out.last_transfer = r_out.last_transfer;
    assign o_out.busy_res      = r_out.busy_res;

    // skid stage never holds data behind an empty output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid while output register empty");

    // a last transfer ends the copy
    a_last_ends_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_active && i_in.opcode == bcd_pkg::OP_TICK
         && r_bytes_left <= bcd_pkg::COUNT_W'(1)) |=> !r_active)
        else $error("copy still active after its last transfer");

    // a busy engine never changes the programmed registers
    a_regs_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |=> ($stable(r_source) && $stable(r_dest) && $stable(r_length)))
        else $error("programmed register changed during a copy");

    // no address is shown without a transfer command
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.xfer_valid) |->
        (r_out.src_address == '0 && r_out.dst_address == '0 && !r_out.last_transfer))
        else $error("transfer fields set without a transfer");

endmodule

/* dv/tb_block_copy_dma_engine_unit.sv */
`timescale 1ns / 1ps

// Tracks the engine's registers and copy progress and holds the results
// expected for accepted transactions, oldest first.
class dma_transfer_tracker;
    logic [7:0]                  ctrl;
    logic [7:0]                  bank;
    logic [15:0]                 src_base;
    logic [15:0]                 dst_base;
    logic [15:0]                 len;
    logic [15:0]                 cur_src;
    logic [15:0]                 cur_dst;
    logic [bcd_pkg::COUNT_W-1:0] remaining;
    bit                          busy;
    bcd_pkg::t_result            expected_results[$];
    int                          errors;
    int                          transactions;
    int                          copies;
    int                          transfers;

    function new();
        ctrl      = '0;
        bank      = '0;
        src_base  = '0;
        dst_base  = '0;
        len       = '0;
        cur_src   = '0;
        cur_dst   = '0;
        remaining = '0;
        busy      = 1'b0;
        errors    = 0;
        transactions = 0;
        copies    = 0;
        transfers = 0;
    endfunction

    function void record_transaction(logic [1:0] op, logic [2:0] sel, logic [7:0] wd);
        bcd_pkg::t_result r;
        r = '0;
        transactions++;
        case (op)
            bcd_pkg::OP_TICK: begin
                if (busy) begin
                    r.xfer_valid = 1'b1;
                    r.src_is_rom = cur_src[15];
                    // ROM space takes the low five bank bits above the 15-bit offset
                    r.src_address = cur_src[15] ? {bank[4:0], cur_src[14:0]}
                                                : {5'd0, cur_src[14:0]};
                    r.dst_is_cpu = ctrl[bcd_pkg::CTRL_DST_BIT];
                    r.dst_address = cur_dst;
                    cur_src = cur_src + 16'd1;
                    cur_dst = cur_dst + 16'd1;
                    if (remaining <= 1) begin
                        remaining = '0;
                        busy = 1'b0;
                        r.last_transfer = 1'b1;
                    end else begin
                        remaining = remaining - 1'b1;
                    end
                end
            end
            bcd_pkg::OP_WRITE: begin
                if (!busy) begin
                    case (sel)
                        bcd_pkg::REG_CONTROL: begin
                            ctrl = wd;
                            if (wd[bcd_pkg::CTRL_START_BIT]) begin
                                cur_src   = src_base;
                                cur_dst   = dst_base;
                                remaining = {1'b0, len} + 1'b1;
                                busy      = 1'b1;
                                copies++;
                            end
                        end
                        bcd_pkg::REG_BANK:   bank = wd;
                        bcd_pkg::REG_SRC_LO: src_base[7:0] = wd;
                        bcd_pkg::REG_SRC_HI: src_base[15:8] = wd;
                        bcd_pkg::REG_DST_LO: dst_base[7:0] = wd;
                        bcd_pkg::REG_DST_HI: dst_base[15:8] = wd;
                        bcd_pkg::REG_LEN_LO: len[7:0] = wd;
                        default:             len[15:8] = wd;
                    endcase
                end
            end
            bcd_pkg::OP_READ: begin
                if (!busy) begin
                    case (sel)
                        bcd_pkg::REG_CONTROL: r.read_data = {1'b0, ctrl[6:0]};
                        bcd_pkg::REG_BANK:    r.read_data = bank;
                        bcd_pkg::REG_SRC_LO:  r.read_data = src_base[7:0];
                        bcd_pkg::REG_SRC_HI:  r.read_data = src_base[15:8];
                        bcd_pkg::REG_DST_LO:  r.read_data = dst_base[7:0];
                        bcd_pkg::REG_DST_HI:  r.read_data = dst_base[15:8];
                        bcd_pkg::REG_LEN_LO:  r.read_data = len[7:0];
                        default:              r.read_data = len[15:8];
                    endcase
                end
            end
            default: ;
        endcase
        r.busy_res = busy;
        expected_results.push_back(r);
    endfunction

    function void compare_result(bcd_pkg::t_result got);
        bcd_pkg::t_result want;
        if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.xfer_valid) transfers++;
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
            errors++;
        end
        if (got.xfer_valid !== want.xfer_valid) begin
            $error("xfer_valid: expected %0h, actual %0h", want.xfer_valid, got.xfer_valid);
            errors++;
        end
        if (got.src_is_rom !== want.src_is_rom) begin
            $error("src_is_rom: expected %0h, actual %0h", want.src_is_rom, got.src_is_rom);
            errors++;
        end
        if (got.src_address !== want.src_address) begin
            $error("src_address: expected %0h, actual %0h", want.src_address,
                   got.src_address);
            errors++;
        end
        if (got.dst_is_cpu !== want.dst_is_cpu) begin
            $error("dst_is_cpu: expected %0h, actual %0h", want.dst_is_cpu, got.dst_is_cpu);
            errors++;
        end
        if (got.dst_address !== want.dst_address) begin
            $error("dst_address: expected %0h, actual %0h", want.dst_address,
                   got.dst_address);
            errors++;
        end
        if (got.last_transfer !== want.last_transfer) begin
            $error("last_transfer: expected %0h, actual %0h", want.last_transfer,
                   got.last_transfer);
            errors++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0h, actual %0h", want.busy_res, got.busy_res);
            errors++;
        end
    endfunction
endclass

module tb_block_copy_dma_engine_unit;

    // opcode 3 has no meaning in the block; it must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 420;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // idle/stall chances in percent, changed per phase
    int send_idle_pct;
    int stall_pct;
    int cycle_count;
    // transactions sent in the current phase
    int phase_items;

    dma_transfer_tracker tracker;

    bcd_in_if  in_bus();
    bcd_out_if out_bus();

    block_copy_dma_engine_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: backpressure rolled fresh every cycle, driven on the falling edge.
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Output monitor plus the runaway guard.
    always @(posedge i_clk) begin
        bcd_pkg::t_result seen;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("block_copy_dma_engine_unit: mismatch");
            $finish;
        end else if (i_rst_n && out_bus.valid && out_bus.ready) begin
            seen = {out_bus.read_data, out_bus.xfer_valid, out_bus.src_is_rom,
                    out_bus.src_address, out_bus.dst_is_cpu, out_bus.dst_address,
                    out_bus.last_transfer, out_bus.busy_res};
            tracker.compare_result(seen);
        end
    end

    // One input transaction. Fields change on the falling edge; the predictor
    // is updated here, at the accepting edge, so later decisions see it.
    task automatic send(input logic [1:0] op, input logic [2:0] sel, input logic [7:0] wd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.opcode     <= op;
        in_bus.reg_offset <= sel;
        in_bus.write_data <= wd;
        do @(posedge i_clk); while (!in_bus.ready);
        tracker.record_transaction(op, sel, wd);
        phase_items++;
    endtask

    // Sender goes quiet until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (tracker.expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic tick();
        send(bcd_pkg::OP_TICK, 3'($urandom_range(7)), 8'($urandom));
    endtask

    // Well-formed copy: finish any running copy, program, start, tick it
    // through with the odd ignored access mixed in.
    task automatic copy_sequence();
        logic [7:0] len_lo;
        logic [7:0] len_hi;
        while (tracker.busy) tick();
        repeat ($urandom_range(4))
            send(bcd_pkg::OP_WRITE,
                 3'($urandom_range(int'(bcd_pkg::REG_BANK), int'(bcd_pkg::REG_DST_HI))),
                 8'($urandom));
        // mostly short copies, now and then a full low byte or a second page
        len_lo = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        len_hi = ($urandom_range(31) == 0) ? 8'd1 : 8'd0;
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_LEN_LO, len_lo);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_LEN_HI, len_hi);
        repeat ($urandom_range(2))
            send(bcd_pkg::OP_READ, 3'($urandom_range(7)), 8'($urandom));
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_CONTROL, {1'b1, 7'($urandom)});
        while (tracker.busy) begin
            if ($urandom_range(9) == 0)
                send(2'($urandom_range(1, 3)), 3'($urandom_range(7)), 8'($urandom));
            else
                tick();
        end
        if ($urandom_range(3) == 0)
            send(bcd_pkg::OP_READ, bcd_pkg::REG_CONTROL, 8'($urandom));
    endtask

    // Unstructured transactions; a start is suppressed when the stored length
    // would make the copy very long.
    task automatic noise_burst();
        logic [1:0] op;
        logic [2:0] sel;
        logic [7:0] wd;
        repeat ($urandom_range(1, 6)) begin
            op  = 2'($urandom_range(3));
            sel = 3'($urandom_range(7));
            wd  = 8'($urandom);
            if (op == bcd_pkg::OP_WRITE && sel == bcd_pkg::REG_CONTROL
                && tracker.len > 16'h01ff)
                wd[bcd_pkg::CTRL_START_BIT] = 1'b0;
            send(op, sel, wd);
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.opcode     = bcd_pkg::OP_TICK;
        in_bus.reg_offset = bcd_pkg::REG_CONTROL;
        in_bus.write_data = 8'd0;
        out_bus.ready     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        phase_items   = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        send(bcd_pkg::OP_TICK, bcd_pkg::REG_LEN_HI, 8'hff);     // tick while idle: all zero
        send(OP_UNUSED, bcd_pkg::REG_CONTROL, 8'hff);           // unused opcode, idle
        send(bcd_pkg::OP_READ, bcd_pkg::REG_CONTROL, 8'h00);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_BANK, 8'hff);
        send(bcd_pkg::OP_READ, bcd_pkg::REG_BANK, 8'h00);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_SRC_LO, 8'hff);    // source 0xffff: ROM, wraps
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_SRC_HI, 8'hff);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_DST_LO, 8'hfe);    // destination wraps
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_DST_HI, 8'hff);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_LEN_LO, 8'h02);    // three bytes
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_LEN_HI, 8'h00);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_CONTROL, 8'h20);   // stored, no start
        send(bcd_pkg::OP_READ, bcd_pkg::REG_CONTROL, 8'h00);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_CONTROL, 8'hff);   // start, CPU RAM destination
        send(bcd_pkg::OP_READ, bcd_pkg::REG_SRC_LO, 8'h00);     // busy: reads zero
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_BANK, 8'h00);      // busy: ignored
        send(OP_UNUSED, bcd_pkg::REG_BANK, 8'h00);              // busy: only busy_res set
        repeat (3) send(bcd_pkg::OP_TICK, bcd_pkg::REG_CONTROL, 8'h00);
        send(bcd_pkg::OP_TICK, bcd_pkg::REG_CONTROL, 8'h00);    // idle again
        send(bcd_pkg::OP_READ, bcd_pkg::REG_CONTROL, 8'h00);    // start bit kept but masked
        send(bcd_pkg::OP_READ, bcd_pkg::REG_BANK, 8'h00);
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_LEN_LO, 8'h00);    // single-byte copy
        send(bcd_pkg::OP_WRITE, bcd_pkg::REG_CONTROL, 8'h80);   // video destination
        send(bcd_pkg::OP_TICK, bcd_pkg::REG_CONTROL, 8'h00);
        send(bcd_pkg::OP_READ, bcd_pkg::REG_SRC_HI, 8'h00);
        send(bcd_pkg::OP_READ, bcd_pkg::REG_DST_LO, 8'h00);
        send(bcd_pkg::OP_READ, bcd_pkg::REG_DST_HI, 8'h00);
        send(bcd_pkg::OP_READ, bcd_pkg::REG_LEN_LO, 8'h00);

        // ---- random phases: none, sender idle, receiver stall, both ----
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(4) != 0) copy_sequence();
                else noise_burst();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d transactions: %0d copies started, %0d byte transfers checked,",
                 tracker.transactions, tracker.copies, tracker.transfers);
        $display("with address wrap, busy-time accesses and four pressure phases.");
        if (tracker.errors == 0) begin
            $display("block_copy_dma_engine_unit: match");
        end else begin
            $display("block_copy_dma_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
